// File: sv/rqmd_pkg.sv
// Package for the receive queue mark decision block.
// Holds transaction types, configuration codes and arithmetic constants.
// Used by rqmd_datapath and receive_queue_mark_decision.
package rqmd_pkg;

   // Number of register stages from the request port to the response port.
   localparam int STAGES = 7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_AQM_MODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_PAGES    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SHIFT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA_GAIN       = 3'd4;

   // Marking modes.
   localparam logic [1:0] MODE_NEVER     = 2'd0;
   localparam logic [1:0] MODE_PAGES     = 2'd1;
   localparam logic [1:0] MODE_RATE      = 2'd2;
   localparam logic [1:0] MODE_RANDOMIZE = 2'd3;

   // Arithmetic constants of the rate comparison.
   localparam logic [13:0] RATE_SCALE      = 14'd12500;
   localparam int          RAND_PRE_SHIFT  = 24;
   localparam int          RAND_POST_SHIFT = 8;

   // Reset values of the registers.
   localparam logic [1:0]  AQM_MODE_RESET        = MODE_NEVER;
   localparam logic [31:0] QUEUE_THRESHOLD_RESET = 32'd65536;
   localparam logic [31:0] TARGET_PAGES_RESET    = 32'd2048;
   localparam logic [4:0]  ALPHA_SHIFT_RESET     = 5'd2;
   localparam logic [15:0] BETA_GAIN_RESET       = 16'd1;

   typedef struct packed {
      logic [1:0]  aqm_mode;
      logic [31:0] queue_threshold;
      logic [31:0] target_pages;
      logic [4:0]  alpha_shift;
      logic [15:0] beta_gain;
   } cfg_type;

   typedef struct packed {
      logic        has_pool;
      logic [31:0] rcv_next_seq;
      logic [31:0] copied_sequence;
      logic [31:0] backlog_bytes;
      logic [31:0] rate_delta;
      logic [31:0] copy_rate;
      logic [31:0] pool_pages;
      logic [15:0] segment_size;
      logic [31:0] random_word;
   } req_type;

   typedef struct packed {
      logic mark;
      logic ack;
   } rsp_type;

endpackage

// File: sv/receive_queue_mark_decision.sv
// Top level of the receive queue mark decision: configuration registers,
// per-stage flow control and the datapath. Depends on rqmd_pkg and rqmd_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data (req_type)
//   rsp      out        rsp_valid / rsp_stall  rsp_data (rsp_type)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Every request yields one response through a seven-stage pipeline, and one
// transaction can enter in every cycle while req_stall is low.
// The depth is set by the chain of multipliers, each split to 32 bits or less.
// Reset restores the register defaults and empties the pipeline.
// A stall on rsp only holds the stages that are full; bubbles still close up,
// so req_stall rises only when all seven stages hold a transaction.
module receive_queue_mark_decision
   import rqmd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AQM_MODE:        cfg_in.aqm_mode        = csr_data[1:0];
            CSR_QUEUE_THRESHOLD: cfg_in.queue_threshold = csr_data;
            CSR_TARGET_PAGES:    cfg_in.target_pages    = csr_data;
            CSR_ALPHA_SHIFT:     cfg_in.alpha_shift     = csr_data[4:0];
            CSR_BETA_GAIN:       cfg_in.beta_gain       = csr_data[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aqm_mode        <= AQM_MODE_RESET;
         cfg_ff.queue_threshold <= QUEUE_THRESHOLD_RESET;
         cfg_ff.target_pages    <= TARGET_PAGES_RESET;
         cfg_ff.alpha_shift     <= ALPHA_SHIFT_RESET;
         cfg_ff.beta_gain       <= BETA_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A stage may load when it is empty or when the stage after it loads.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] load;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      for (int k = 0; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   rqmd_datapath u_datapath (
      .clock    (clock),
      .cfg      (cfg_ff),
      .load     (load),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // The request side is held off only when every stage is occupied.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> &valid_ff)
      else $error("request stalled while the pipeline has a free stage");

   // An accepted transaction lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted transaction missing from the first stage");

   // A transaction leaving the last stage is replaced only by one from the stage before.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !valid_ff[STAGES-2] |=> !rsp_valid)
      else $error("response appeared without a transaction behind it");

endmodule

// File: sv/rqmd_datapath.sv
// Seven-stage datapath of the receive queue mark decision.
// Depends on rqmd_pkg; stage loads are driven by the top level's flow control.
module rqmd_datapath
   import rqmd_pkg::*;
(
   input  logic              clock,
   input  cfg_type           cfg,
   input  logic [STAGES-1:0] load,
   input  req_type           req_data,
   output rsp_type           rsp_data
);

   localparam int HALF = 24;

   // Stage 1: queue length, shifted estimates, remaining pages, compares.
   logic        s1_pool_ff,  s1_pool_in;
   logic        s1_ge_ff,    s1_ge_in;
   logic        s1_gt_ff,    s1_gt_in;
   logic [31:0] s1_qlen_ff,  s1_qlen_in;
   logic [31:0] s1_rtt_ff,   s1_rtt_in;
   logic [31:0] s1_drain_ff, s1_drain_in;
   logic [31:0] s1_rem_ff,   s1_rem_in;
   logic [15:0] s1_seg_ff;
   logic [31:0] s1_rnd_ff;

   always_comb begin
      s1_pool_in  = req_data.has_pool;
      s1_qlen_in  = (req_data.rcv_next_seq - req_data.copied_sequence) + req_data.backlog_bytes;
      s1_rtt_in   = req_data.rate_delta >> cfg.alpha_shift;
      s1_drain_in = req_data.copy_rate >> cfg.alpha_shift;
      s1_rem_in   = (cfg.target_pages > req_data.pool_pages) ?
                    (cfg.target_pages - req_data.pool_pages) : 32'd0;
      s1_ge_in    = req_data.pool_pages >= cfg.queue_threshold;
      s1_gt_in    = s1_qlen_in > cfg.queue_threshold;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_pool_ff  <= s1_pool_in;
         s1_ge_ff    <= s1_ge_in;
         s1_gt_ff    <= s1_gt_in;
         s1_qlen_ff  <= s1_qlen_in;
         s1_rtt_ff   <= s1_rtt_in;
         s1_drain_ff <= s1_drain_in;
         s1_rem_ff   <= s1_rem_in;
         s1_seg_ff   <= req_data.segment_size;
         s1_rnd_ff   <= req_data.random_word;
      end
   end

   // Stage 2: first level of products.
   logic        s2_pool_ff, s2_ge_ff, s2_gt_ff;
   logic [63:0] s2_qr_ff;
   logic [47:0] s2_rs_ff;
   logic [47:0] s2_db_ff;
   logic [31:0] s2_rnd_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_pool_ff <= s1_pool_ff;
         s2_ge_ff   <= s1_ge_ff;
         s2_gt_ff   <= s1_gt_ff;
         s2_qr_ff   <= 64'(s1_qlen_ff) * 64'(s1_rtt_ff);
         s2_rs_ff   <= 48'(s1_rem_ff) * 48'(s1_seg_ff);
         s2_db_ff   <= 48'(s1_drain_ff) * 48'(cfg.beta_gain);
         s2_rnd_ff  <= s1_rnd_ff;
      end
   end

   // Stage 3: partial products of both 64-bit products.
   logic        s3_pool_ff, s3_ge_ff, s3_gt_ff;
   logic [45:0] s3_ll_ff;
   logic [31:0] s3_lh_ff;
   logic [47:0] s3_pp00_ff, s3_pp01_ff, s3_pp10_ff, s3_pp11_ff;
   logic [31:0] s3_rnd_ff;
   logic [45:0] s3_lh_full;

   assign s3_lh_full = 46'(s2_qr_ff[63:32]) * 46'(RATE_SCALE);

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_pool_ff <= s2_pool_ff;
         s3_ge_ff   <= s2_ge_ff;
         s3_gt_ff   <= s2_gt_ff;
         s3_ll_ff   <= 46'(s2_qr_ff[31:0]) * 46'(RATE_SCALE);
         s3_lh_ff   <= s3_lh_full[31:0];
         s3_pp00_ff <= 48'(s2_rs_ff[HALF-1:0]) * 48'(s2_db_ff[HALF-1:0]);
         s3_pp01_ff <= 48'(s2_rs_ff[HALF-1:0]) * 48'(s2_db_ff[2*HALF-1:HALF]);
         s3_pp10_ff <= 48'(s2_rs_ff[2*HALF-1:HALF]) * 48'(s2_db_ff[HALF-1:0]);
         s3_pp11_ff <= 48'(s2_rs_ff[2*HALF-1:HALF]) * 48'(s2_db_ff[2*HALF-1:HALF]);
         s3_rnd_ff  <= s2_rnd_ff;
      end
   end

   // Stage 4: sum the partial products modulo 2^64.
   logic        s4_pool_ff, s4_ge_ff, s4_gt_ff;
   logic [63:0] s4_lhs_ff;
   logic [63:0] s4_rhs_ff;
   logic [31:0] s4_rnd_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_pool_ff <= s3_pool_ff;
         s4_ge_ff   <= s3_ge_ff;
         s4_gt_ff   <= s3_gt_ff;
         s4_lhs_ff  <= 64'(s3_ll_ff) + {s3_lh_ff, 32'd0};
         s4_rhs_ff  <= 64'(s3_pp00_ff) + (64'(s3_pp01_ff) << HALF)
                     + (64'(s3_pp10_ff) << HALF) + (64'(s3_pp11_ff) << (2 * HALF));
         s4_rnd_ff  <= s3_rnd_ff;
      end
   end

   // Stage 5: partial products of the randomized right side.
   logic        s5_pool_ff, s5_ge_ff, s5_gt_ff;
   logic [63:0] s5_lhs_ff;
   logic [63:0] s5_rhs_ff;
   logic [63:0] s5_q0_ff;
   logic [31:0] s5_q1_ff;
   logic [39:0] s5_scaled;
   logic [39:0] s5_q1_full;

   assign s5_scaled  = 40'(s4_rhs_ff >> RAND_PRE_SHIFT);
   assign s5_q1_full = 40'(s5_scaled[39:32]) * 40'(s4_rnd_ff);

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_pool_ff <= s4_pool_ff;
         s5_ge_ff   <= s4_ge_ff;
         s5_gt_ff   <= s4_gt_ff;
         s5_lhs_ff  <= s4_lhs_ff;
         s5_rhs_ff  <= s4_rhs_ff;
         s5_q0_ff   <= 64'(s5_scaled[31:0]) * 64'(s4_rnd_ff);
         s5_q1_ff   <= s5_q1_full[31:0];
      end
   end

   // Stage 6: finish the randomized product and pick the right side.
   logic        s6_pool_ff, s6_ge_ff, s6_gt_ff;
   logic [63:0] s6_lhs_ff;
   logic [63:0] s6_rhs_ff, s6_rhs_in;
   logic [63:0] s6_prod;

   always_comb begin
      s6_prod = s5_q0_ff + {s5_q1_ff, 32'd0};
      if (cfg.aqm_mode == MODE_RANDOMIZE) begin
         s6_rhs_in = s6_prod >> RAND_POST_SHIFT;
      end else begin
         s6_rhs_in = s5_rhs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s6_pool_ff <= s5_pool_ff;
         s6_ge_ff   <= s5_ge_ff;
         s6_gt_ff   <= s5_gt_ff;
         s6_lhs_ff  <= s5_lhs_ff;
         s6_rhs_ff  <= s6_rhs_in;
      end
   end

   // Stage 7: final compare and the response register.
   logic    s7_mark;
   rsp_type s7_rsp_ff, s7_rsp_in;

   always_comb begin
      case (cfg.aqm_mode)
         MODE_NEVER:     s7_mark = 1'b0;
         MODE_PAGES:     s7_mark = s6_ge_ff;
         MODE_RATE,
         MODE_RANDOMIZE: s7_mark = s6_gt_ff && (s6_lhs_ff > s6_rhs_ff);
         default:        s7_mark = 1'b0;
      endcase
      // Without a pool the packet is always acknowledged and never marked.
      s7_rsp_in.mark = s6_pool_ff && s7_mark;
      s7_rsp_in.ack  = !s7_rsp_in.mark;
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         s7_rsp_ff <= s7_rsp_in;
      end
   end

   assign rsp_data = s7_rsp_ff;

endmodule
